[sv/xrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_pkg: shared types and constants
// Generator seeds, configuration codes and the entry format that travels
// from the front part through the queue to the back part.
// ----------------------------------------------------------------------------
package xrr_pkg;

   localparam int WordBits  = 64;
   localparam int RangeBits = 32;
   localparam int DivSteps  = WordBits;

   localparam logic [WordBits-1:0] SEED_X = 64'd10596601668567;
   localparam logic [WordBits-1:0] SEED_Y = 64'd60441451194812;
   localparam logic [WordBits-1:0] SEED_Z = 64'd34516354845907;

   localparam int ShiftA = 16;
   localparam int ShiftB = 5;
   localparam int ShiftC = 1;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_UPPER = 2'd1;
   localparam logic [1:0] CSR_LOW   = 2'd2;
   localparam logic [1:0] CSR_HIGH  = 2'd3;

   // reduce modes
   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_MOD   = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;

   typedef enum logic [2:0] {
      KIND_PASS,
      KIND_ZERO,
      KIND_MOD,
      KIND_RANGE,
      KIND_FAULT
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [WordBits-1:0]     raw;
      logic [WordBits-1:0]     divisor;
      logic [RangeBits-1:0]    low;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[sv/xrr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_req_if: draw request channel
// Valid/ready channel carrying one draw request bit per beat.
// ----------------------------------------------------------------------------
interface xrr_req_if;
   logic valid;
   logic ready;
   logic draw;

   modport source (output valid, output draw, input ready);
   modport sink   (input valid, input draw, output ready);
endinterface

[sv/xrr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_rsp_if: draw result channel
// Valid/ready channel carrying the raw word, reduced value and range flag.
// ----------------------------------------------------------------------------
interface xrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] raw_word;
   logic [63:0] reduced_value;
   logic        range_error;

   modport source (output valid, output raw_word, output reduced_value,
                   output range_error, input ready);
   modport sink   (input valid, input raw_word, input reduced_value,
                   input range_error, output ready);
endinterface

[sv/xrr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_front: generator and classifier
// Accepts draw beats, advances the xorshift96 state and pushes one entry
// per draw that tells the back part how to reduce the new word.
// ----------------------------------------------------------------------------
module xrr_front (
   input  logic                clock,
   input  logic                reset,
   xrr_req_if.sink             req_ch,
   input  logic [1:0]          mode,
   input  logic [63:0]         upper_bound,
   input  logic [31:0]         range_low,
   input  logic [31:0]         range_high,
   input  xrr_pkg::qstat_type  qstat,
   output xrr_pkg::push_type   push
);

   logic [63:0] x_ff, y_ff, z_ff;
   logic [63:0] x_in, y_in, z_in;
   logic [63:0] t1, t2, t3, new_z, span;
   logic        accept, take, bad_range;
   xrr_pkg::kind_type kind;

   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign take         = accept && req_ch.draw;

   always_comb begin
      t1    = x_ff ^ (x_ff << xrr_pkg::ShiftA);
      t2    = t1 ^ (t1 >> xrr_pkg::ShiftB);
      t3    = t2 ^ (t2 << xrr_pkg::ShiftC);
      new_z = t3 ^ y_ff ^ z_ff;
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (take) begin
         x_in = y_ff;
         y_in = z_ff;
         z_in = new_z;
      end
   end

   always_comb begin
      bad_range = $signed(range_high) < $signed(range_low);
      span      = {{32{range_high[31]}}, range_high}
                - {{32{range_low[31]}}, range_low} + 64'd1;
      unique case (mode)
         xrr_pkg::MODE_MOD: begin
            kind = (upper_bound == 64'd0) ? xrr_pkg::KIND_ZERO : xrr_pkg::KIND_MOD;
         end
         xrr_pkg::MODE_RANGE: begin
            kind = bad_range ? xrr_pkg::KIND_FAULT : xrr_pkg::KIND_RANGE;
         end
         default: begin
            kind = xrr_pkg::KIND_PASS;
         end
      endcase
   end

   always_comb begin
      push.valid         = take;
      push.entry.kind    = kind;
      push.entry.raw     = new_z;
      push.entry.divisor = (mode == xrr_pkg::MODE_RANGE) ? span : upper_bound;
      push.entry.low     = range_low;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= xrr_pkg::SEED_X;
         y_ff <= xrr_pkg::SEED_Y;
         z_ff <= xrr_pkg::SEED_Z;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

[sv/xrr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_queue: entry queue
// Small FIFO between the front and back parts so each side stalls alone.
// ----------------------------------------------------------------------------
module xrr_queue #(
   parameter int Depth = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  xrr_pkg::push_type   push,
   input  logic                pop,
   output xrr_pkg::qstat_type  qstat,
   output xrr_pkg::entry_type  head
);

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

   xrr_pkg::entry_type    store_ff [Depth];
   logic [PtrBits-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign qstat.full  = (cnt_ff == FullCnt);
   assign qstat.empty = (cnt_ff == '0);
   assign head        = store_ff[rd_ff];
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntBits'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[sv/xrr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_back: reduction engine
// Pops entries, runs a radix-2 restoring remainder over 64 steps where the
// entry needs one, and drives the registered result channel.
// ----------------------------------------------------------------------------
module xrr_back (
   input  logic                clock,
   input  logic                reset,
   input  xrr_pkg::qstat_type  qstat,
   input  xrr_pkg::entry_type  head,
   output logic                pop,
   xrr_rsp_if.source           rsp_ch
);

   localparam int CntBits = $clog2(xrr_pkg::DivSteps);
   localparam logic [CntBits-1:0] LastStep = CntBits'(xrr_pkg::DivSteps - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   xrr_pkg::kind_type  kind_ff, kind_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [63:0]        div_ff, div_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [63:0]        raw_ff, raw_in;
   logic [31:0]        low_ff, low_in;
   logic [63:0]        res_ff, res_in;
   logic               err_ff, err_in;
   logic               ov_ff, ov_in;
   logic [63:0]        oraw_ff, oraw_in, ored_ff, ored_in;
   logic               oerr_ff, oerr_in;

   logic [64:0]        rem_sh;
   logic [63:0]        rem_nx;
   logic [65:0]        diff;
   logic [31:0]        sum32;
   logic               out_free;

   assign rsp_ch.valid         = ov_ff;
   assign rsp_ch.raw_word      = oraw_ff;
   assign rsp_ch.reduced_value = ored_ff;
   assign rsp_ch.range_error   = oerr_ff;

   assign out_free = !ov_ff || rsp_ch.ready;
   assign pop      = (state_ff == S_IDLE) && !qstat.empty;

   // one restoring step; the partial remainder stays below the divisor
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[63]};
      diff   = {1'b0, rem_sh} - {2'b00, div_ff};
      rem_nx = diff[65] ? rem_sh[63:0] : diff[63:0];
      sum32  = rem_nx[31:0] + low_ff;
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      raw_in   = raw_ff;
      low_in   = low_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      ov_in    = ov_ff;
      oraw_in  = oraw_ff;
      ored_in  = ored_ff;
      oerr_in  = oerr_ff;

      if (ov_ff && rsp_ch.ready) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               kind_in = head.kind;
               raw_in  = head.raw;
               low_in  = head.low;
               div_in  = head.divisor;
               dvd_in  = head.raw;
               rem_in  = '0;
               cnt_in  = '0;
               err_in  = 1'b0;
               unique case (head.kind)
                  xrr_pkg::KIND_MOD, xrr_pkg::KIND_RANGE: begin
                     state_in = S_DIV;
                  end
                  xrr_pkg::KIND_ZERO: begin
                     res_in   = '0;
                     state_in = S_DONE;
                  end
                  xrr_pkg::KIND_FAULT: begin
                     res_in   = {{32{head.low[31]}}, head.low};
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end
                  default: begin
                     res_in   = head.raw;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DIV: begin
            rem_in = rem_nx;
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff + CntBits'(1);
            if (cnt_ff == LastStep) begin
               res_in   = (kind_ff == xrr_pkg::KIND_RANGE)
                        ? {{32{sum32[31]}}, sum32} : rem_nx;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ov_in    = 1'b1;
               oraw_in  = raw_ff;
               ored_in  = res_ff;
               oerr_in  = err_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      raw_ff  <= raw_in;
      low_ff  <= low_in;
      res_ff  <= res_in;
      err_ff  <= err_in;
      oraw_ff <= oraw_in;
      ored_ff <= ored_in;
      oerr_ff <= oerr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

[sv/xorshift96_random_range_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift96_random_range_top: xorshift96 generator with range reduction
// Channel    Dir  Handshake     Payload
// req_ch     in   valid/ready   draw
// rsp_ch     out  valid/ready   raw_word, reduced_value, range_error
// csr_*      in   csr_we        csr_index, csr_wdata (write only)
//
// A mode 1 draw with a nonzero bound or a mode 2 draw with a valid range holds
// the back part through the pop, 64 remainder steps and the output load; other
// draws hold it for the pop and the output load only. The queue registers each
// entry before the pop, which comes only while the back part is idle; the front
// takes a beat every cycle while the queue has room. Reset restores seeds, config and control.
// A stalled result holds in the output register while the next one works.
// ----------------------------------------------------------------------------
module xorshift96_random_range_top #(
   parameter int QueueDepth = 2
) (
   input  logic        clock,
   input  logic        reset,
   xrr_req_if.sink     req_ch,
   xrr_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [1:0]  mode_ff;
   logic [63:0] upper_ff;
   logic [31:0] low_ff, high_ff;

   xrr_pkg::push_type  push;
   xrr_pkg::qstat_type qstat;
   xrr_pkg::entry_type head;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= xrr_pkg::MODE_RAW;
         upper_ff <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            xrr_pkg::CSR_MODE:  mode_ff  <= csr_wdata[1:0];
            xrr_pkg::CSR_UPPER: upper_ff <= csr_wdata;
            xrr_pkg::CSR_LOW:   low_ff   <= csr_wdata[31:0];
            xrr_pkg::CSR_HIGH:  high_ff  <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   xrr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .mode        (mode_ff),
      .upper_bound (upper_ff),
      .range_low   (low_ff),
      .range_high  (high_ff),
      .qstat       (qstat),
      .push        (push)
   );

   xrr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   xrr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .qstat  (qstat),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

[sv/xrr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_checker: port-level checks
// Watches the channels of the top level and flags ordering and payload
// slips between draw beats and result beats.
// ----------------------------------------------------------------------------
module xrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_draw,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_raw_word,
   input logic [63:0] rsp_reduced_value,
   input logic        rsp_range_error
);

   logic [7:0] pend_ff, pend_in;
   logic       draw_beat, rsp_beat;

   assign draw_beat = req_valid && req_ready && req_draw;
   assign rsp_beat  = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (draw_beat && !rsp_beat) begin
         pend_in = pend_ff + 8'd1;
      end else if (rsp_beat && !draw_beat) begin
         pend_in = pend_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result without an outstanding draw
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("result shown with no outstanding draw");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_error_sext: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         rsp_reduced_value[63:32] == {32{rsp_reduced_value[31]}})
      else $error("range fault value not sign-extended");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_raw_word) && $stable(rsp_reduced_value)
          && $stable(rsp_range_error)))
      else $error("stalled result changed");

endmodule

bind xorshift96_random_range_top xrr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_draw          (req_ch.draw),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_raw_word      (rsp_ch.raw_word),
   .rsp_reduced_value (rsp_ch.reduced_value),
   .rsp_range_error   (rsp_ch.range_error)
);
